// File: hdl/lr4xo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr4xo_pkg
// Shared types and constants of the four-section crossover filter.
// ----------------------------------------------------------------------------
package lr4xo_pkg;

    // Parameter defaults
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    // Fixed datapath widths
    localparam int HIST_BITS = 32;               // Q1.31 history word
    localparam int XS_BITS   = HIST_BITS + 2;    // x0 +/- 2*x1 + x2
    localparam int GAIN_BITS = 32;               // Q4.28 gain
    localparam int HALF_BITS = 16;               // split point of a multiplier operand

    // History memory: one entry per biquad section
    localparam int NUM_SEC = 4;
    localparam int SEC_W   = 2;
    typedef logic [SEC_W-1:0] sec_idx_t;

    // Product counts of the shared multiplier
    localparam int CNT_W     = 3;
    localparam logic [CNT_W-1:0] SEC_LAST_STEP  = 3'd5;   // three products, two halves each
    localparam logic [CNT_W-1:0] GAIN_LAST_STEP = 3'd2;   // gain in two halves, then last add

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LP_B0       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LP_A1       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LP_A2       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HP_B0       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HP_A1       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HP_A2       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN    = 3'd7;

    // Filter modes (any other code runs both cascades)
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HP = 2'd1;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 32'h1000_0000;

    // One history entry: two input taps and two output taps
    typedef struct packed {
        logic [HIST_BITS-1:0] xh0;
        logic [HIST_BITS-1:0] xh1;
        logic [HIST_BITS-1:0] yh0;
        logic [HIST_BITS-1:0] yh1;
    } hist_ent_t;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;       // load the rounding constant into the accumulator
        logic rnd_out;   // rounding constant of the output stage, else of a section
        logic mul_en;    // register a new product
        logic hi;        // product belongs to the upper operand half
    } mac_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_WRITE,
        ST_GAIN,
        ST_GDRAIN
    } seq_state_t;

endpackage
`default_nettype wire

// File: hdl/lr4xo_hist_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr4xo_hist_mem
// Section history memory, one read and one write port, registered read data.
// ----------------------------------------------------------------------------
module lr4xo_hist_mem (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire lr4xo_pkg::sec_idx_t  rd_addr,
    output lr4xo_pkg::hist_ent_t      rd_data,
    input  wire logic                 wr_en,
    input  wire lr4xo_pkg::sec_idx_t  wr_addr,
    input  wire lr4xo_pkg::hist_ent_t wr_data
);

    lr4xo_pkg::hist_ent_t mem [lr4xo_pkg::NUM_SEC];
    lr4xo_pkg::hist_ent_t rd_data_reg;
    logic [lr4xo_pkg::NUM_SEC-1:0] valid_reg;

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hdl/lr4xo_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr4xo_mac
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// ----------------------------------------------------------------------------
module lr4xo_mac #(
    parameter int SAMPLE_BITS = lr4xo_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = lr4xo_pkg::COEF_BITS_DEF,
    localparam int MA_W =
        (COEF_BITS - lr4xo_pkg::HALF_BITS > lr4xo_pkg::HALF_BITS + 1)
            ? COEF_BITS - lr4xo_pkg::HALF_BITS : lr4xo_pkg::HALF_BITS + 1
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lr4xo_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [MA_W-1:0]                op_a,
    input  wire logic signed [lr4xo_pkg::XS_BITS-1:0]  op_b,
    output logic signed [lr4xo_pkg::HIST_BITS-1:0]     sec_y,
    output logic signed [SAMPLE_BITS-1:0]              out_y
);

    localparam int HB     = lr4xo_pkg::HALF_BITS;
    localparam int PW     = MA_W + lr4xo_pkg::XS_BITS;
    localparam int ACC_W  = (COEF_BITS + 34 > 66) ? COEF_BITS + 34 : 66;
    localparam int FRAC   = COEF_BITS - 2;
    localparam int OUT_SH = 60 - SAMPLE_BITS;
    localparam int YW     = lr4xo_pkg::HIST_BITS;

    localparam logic signed [ACC_W-1:0] ONE     = {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_W-1:0] SEC_RND = ONE << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] OUT_RND = ONE << (OUT_SH - 1);
    localparam logic signed [ACC_W-1:0] SEC_MAX = {{(ACC_W-YW+1){1'b0}}, {(YW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SEC_MIN = ~SEC_MAX;
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

    logic signed [PW-1:0]    prod_reg;
    logic                    hi_reg;
    logic                    add_pend_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] sec_shift;
    logic signed [ACC_W-1:0] out_shift;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_a * op_b;
            hi_reg   <= ctrl.hi;
        end
    end

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        if (hi_reg)
        begin
            prod_ext = prod_ext <<< HB;
        end
        if (ctrl.clr)
        begin
            acc_next = ctrl.rnd_out ? OUT_RND : SEC_RND;
        end
        else if (add_pend_reg)
        begin
            acc_next = acc_reg + prod_ext;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_pend_reg <= 1'b0;
        end
        else
        begin
            add_pend_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Round half up by the preloaded constant, then saturate
    always_comb
    begin
        sec_shift = acc_reg >>> FRAC;
        out_shift = acc_reg >>> OUT_SH;
        if (sec_shift > SEC_MAX)
        begin
            sec_y = SEC_MAX[YW-1:0];
        end
        else if (sec_shift < SEC_MIN)
        begin
            sec_y = SEC_MIN[YW-1:0];
        end
        else
        begin
            sec_y = sec_shift[YW-1:0];
        end
        if (out_shift > OUT_MAX)
        begin
            out_y = OUT_MAX[SAMPLE_BITS-1:0];
        end
        else if (out_shift < OUT_MIN)
        begin
            out_y = OUT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            out_y = out_shift[SAMPLE_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// File: hdl/lr4_crossover_band_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr4_crossover_band_filter
// Fourth-order crossover filter: low-pass, high-pass or band-pass cascades of
// Direct Form I biquads, output gain and saturation to SAMPLE_BITS (default 24).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (in_valid/in_ready, in_sample, block_end): one sample a beat.
//   Output channel (out_valid/out_ready, out_sample, block_last): one beat per
//   input beat, in order; block_last copies block_end.
//   Configuration: cfg_wr_en writes cfg_data to register cfg_index at once.
//   Write only while no sample is in flight.
// Sequence:
//   Each biquad section does one history read, one load, six products on
//   the single shared multiplier (each coefficient in two halves), a drain
//   step and one history write-back. The gain stage multiplies by the gain
//   in two halves, adds the last product and waits for the output register.
//   Low-pass and high-pass run 2 sections, band-pass 4. A new beat is
//   taken only after the previous result has entered the output register.
// Reset:
//   rst_n clears all section history, coefficients to zero, gain to unity
//   and low-pass mode. History of unused sections is kept across modes.
// Stall:
//   The result waits in the output register; the next sample is accepted and
//   processed meanwhile, and holds only at the end if out_ready stays low.
// ----------------------------------------------------------------------------
module lr4_crossover_band_filter #(
    parameter int SAMPLE_BITS = lr4xo_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = lr4xo_pkg::COEF_BITS_DEF,
    localparam int CFG_W = (COEF_BITS > lr4xo_pkg::GAIN_BITS) ? COEF_BITS
                                                              : lr4xo_pkg::GAIN_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lr4xo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]                    cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       in_sample,
    input  wire logic                                block_end,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]            out_sample,
    output logic                                     block_last
);

    localparam int HB    = lr4xo_pkg::HALF_BITS;
    localparam int HI_W  = COEF_BITS - HB;
    localparam int MA_W  = (HI_W > HB + 1) ? HI_W : HB + 1;
    localparam int YW    = lr4xo_pkg::HIST_BITS;
    localparam int XSW   = lr4xo_pkg::XS_BITS;
    localparam int IN_SH = YW - SAMPLE_BITS;

    // Configuration registers
    logic [lr4xo_pkg::MODE_W-1:0]    mode_reg;
    logic signed [COEF_BITS-1:0]     lp_b0_reg;
    logic signed [COEF_BITS-1:0]     lp_a1_reg;
    logic signed [COEF_BITS-1:0]     lp_a2_reg;
    logic signed [COEF_BITS-1:0]     hp_b0_reg;
    logic signed [COEF_BITS-1:0]     hp_a1_reg;
    logic signed [COEF_BITS-1:0]     hp_a2_reg;
    logic [lr4xo_pkg::GAIN_BITS-1:0] gain_reg;

    // Sequencer and datapath registers
    lr4xo_pkg::seq_state_t           state_reg;
    lr4xo_pkg::seq_state_t           state_next;
    lr4xo_pkg::sec_idx_t             sec_reg;
    logic [lr4xo_pkg::CNT_W-1:0]     cnt_reg;
    logic signed [YW-1:0]            x_reg;
    logic                            last_reg;
    logic signed [XSW-1:0]           xs_reg;
    lr4xo_pkg::hist_ent_t            hist_reg;
    logic                            out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   out_sample_reg;
    logic                            block_last_reg;

    // Control and datapath nets
    logic                            in_fire;
    logic                            out_load;
    logic                            to_gain;
    logic                            mem_rd_en;
    logic                            mem_wr_en;
    lr4xo_pkg::hist_ent_t            mem_rd_data;
    lr4xo_pkg::hist_ent_t            mem_wr_data;
    lr4xo_pkg::mac_ctrl_t            mac_ctrl;
    logic signed [MA_W-1:0]          op_a;
    logic signed [XSW-1:0]           op_b;
    logic signed [YW-1:0]            sec_y;
    logic signed [SAMPLE_BITS-1:0]   out_y;
    logic signed [YW-1:0]            x_in;
    logic signed [COEF_BITS-1:0]     coef;
    logic signed [COEF_BITS-1:0]     b0_sel;
    logic signed [COEF_BITS-1:0]     a1_sel;
    logic signed [COEF_BITS-1:0]     a2_sel;
    logic [XSW-1:0]                  xs_next;
    logic [XSW-1:0]                  ext_x;
    logic [XSW-1:0]                  ext_h0;
    logic [XSW-1:0]                  ext_h1;
    logic signed [XSW-1:0]           neg_yh0;
    logic signed [XSW-1:0]           neg_yh1;
    logic signed [XSW-1:0]           gain_b;

    assign in_fire = in_valid && in_ready;
    assign x_in    = YW'(in_sample) <<< IN_SH;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lr4xo_pkg::MODE_LP;
            lp_b0_reg <= '0;
            lp_a1_reg <= '0;
            lp_a2_reg <= '0;
            hp_b0_reg <= '0;
            hp_a1_reg <= '0;
            hp_a2_reg <= '0;
            gain_reg  <= lr4xo_pkg::GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lr4xo_pkg::REG_FILTER_MODE: mode_reg  <= cfg_data[lr4xo_pkg::MODE_W-1:0];
                lr4xo_pkg::REG_LP_B0:       lp_b0_reg <= cfg_data[COEF_BITS-1:0];
                lr4xo_pkg::REG_LP_A1:       lp_a1_reg <= cfg_data[COEF_BITS-1:0];
                lr4xo_pkg::REG_LP_A2:       lp_a2_reg <= cfg_data[COEF_BITS-1:0];
                lr4xo_pkg::REG_HP_B0:       hp_b0_reg <= cfg_data[COEF_BITS-1:0];
                lr4xo_pkg::REG_HP_A1:       hp_a1_reg <= cfg_data[COEF_BITS-1:0];
                lr4xo_pkg::REG_HP_A2:       hp_a2_reg <= cfg_data[COEF_BITS-1:0];
                lr4xo_pkg::REG_OUT_GAIN:    gain_reg  <= cfg_data[lr4xo_pkg::GAIN_BITS-1:0];
                default:                    mode_reg  <= mode_reg;
            endcase
        end
    end

    // Upper section index bit selects the high-pass cascade
    always_comb
    begin
        b0_sel = sec_reg[1] ? hp_b0_reg : lp_b0_reg;
        a1_sel = sec_reg[1] ? hp_a1_reg : lp_a1_reg;
        a2_sel = sec_reg[1] ? hp_a2_reg : lp_a2_reg;
    end

    // Feedforward sum x0 + 2*x1 + x2, or x0 - 2*x1 + x2 for high-pass
    always_comb
    begin
        ext_x  = {{2{x_reg[YW-1]}}, x_reg};
        ext_h0 = {{2{mem_rd_data.xh0[YW-1]}}, mem_rd_data.xh0};
        ext_h1 = {{2{mem_rd_data.xh1[YW-1]}}, mem_rd_data.xh1};
        if (sec_reg[1])
        begin
            xs_next = ext_x - (ext_h0 << 1) + ext_h1;
        end
        else
        begin
            xs_next = ext_x + (ext_h0 << 1) + ext_h1;
        end
        neg_yh0 = -{{2{hist_reg.yh0[YW-1]}}, hist_reg.yh0};
        neg_yh1 = -{{2{hist_reg.yh1[YW-1]}}, hist_reg.yh1};
        gain_b  = {{2{x_reg[YW-1]}}, x_reg};
    end

    // Last section of the active cascades hands over to the gain stage
    assign to_gain = sec_reg[0] &&
                     (sec_reg[1] || (mode_reg == lr4xo_pkg::MODE_LP));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lr4xo_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = lr4xo_pkg::ST_READ;
                end
            end
            lr4xo_pkg::ST_READ:  state_next = lr4xo_pkg::ST_LOAD;
            lr4xo_pkg::ST_LOAD:  state_next = lr4xo_pkg::ST_MAC;
            lr4xo_pkg::ST_MAC:
            begin
                if (cnt_reg == lr4xo_pkg::SEC_LAST_STEP)
                begin
                    state_next = lr4xo_pkg::ST_DRAIN;
                end
            end
            lr4xo_pkg::ST_DRAIN: state_next = lr4xo_pkg::ST_WRITE;
            lr4xo_pkg::ST_WRITE:
            begin
                state_next = to_gain ? lr4xo_pkg::ST_GAIN : lr4xo_pkg::ST_READ;
            end
            lr4xo_pkg::ST_GAIN:
            begin
                if (cnt_reg == lr4xo_pkg::GAIN_LAST_STEP)
                begin
                    state_next = lr4xo_pkg::ST_GDRAIN;
                end
            end
            lr4xo_pkg::ST_GDRAIN:
            begin
                if (out_load)
                begin
                    state_next = lr4xo_pkg::ST_IDLE;
                end
            end
            default: state_next = lr4xo_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports, multiplier operands, handshake
    always_comb
    begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        mac_ctrl  = '0;
        coef      = b0_sel;
        op_b      = xs_reg;
        op_a      = '0;
        case (state_reg)
            lr4xo_pkg::ST_IDLE:  in_ready  = 1'b1;
            lr4xo_pkg::ST_READ:  mem_rd_en = 1'b1;
            lr4xo_pkg::ST_LOAD:  mac_ctrl.clr = 1'b1;
            lr4xo_pkg::ST_MAC:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.hi     = ~cnt_reg[0];
                case (cnt_reg[2:1])
                    2'd0:
                    begin
                        coef = b0_sel;
                        op_b = xs_reg;
                    end
                    2'd1:
                    begin
                        coef = a1_sel;
                        op_b = neg_yh0;
                    end
                    default:
                    begin
                        coef = a2_sel;
                        op_b = neg_yh1;
                    end
                endcase
                // Upper half signed, lower half unsigned
                if (cnt_reg[0])
                begin
                    op_a = MA_W'($signed({1'b0, coef[HB-1:0]}));
                end
                else
                begin
                    op_a = MA_W'($signed(coef[COEF_BITS-1:HB]));
                end
            end
            lr4xo_pkg::ST_WRITE:
            begin
                mem_wr_en        = 1'b1;
                mac_ctrl.clr     = to_gain;
                mac_ctrl.rnd_out = 1'b1;
            end
            lr4xo_pkg::ST_GAIN:
            begin
                // Last gain cycle only adds the lower-half product
                mac_ctrl.mul_en = (cnt_reg != lr4xo_pkg::GAIN_LAST_STEP);
                mac_ctrl.hi     = ~cnt_reg[0];
                op_b            = gain_b;
                if (cnt_reg[0])
                begin
                    op_a = MA_W'($signed({1'b0, gain_reg[HB-1:0]}));
                end
                else
                begin
                    op_a = MA_W'($signed({1'b0, gain_reg[lr4xo_pkg::GAIN_BITS-1:HB]}));
                end
            end
            lr4xo_pkg::ST_GDRAIN:
            begin
                // Hold the result until the output register frees up
                out_load = !out_valid_reg || out_ready;
            end
            default: in_ready = 1'b0;
        endcase
    end

    assign mem_wr_data = '{xh0: x_reg, xh1: hist_reg.xh0, yh0: sec_y, yh1: hist_reg.yh0};

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lr4xo_pkg::ST_IDLE;
            sec_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                lr4xo_pkg::ST_IDLE:
                begin
                    // High-pass mode skips the low-pass sections
                    sec_reg <= (mode_reg == lr4xo_pkg::MODE_HP) ? lr4xo_pkg::sec_idx_t'(2)
                                                                : '0;
                end
                lr4xo_pkg::ST_LOAD:  cnt_reg <= '0;
                lr4xo_pkg::ST_MAC:   cnt_reg <= cnt_reg + 1'b1;
                lr4xo_pkg::ST_WRITE:
                begin
                    cnt_reg <= '0;
                    if (!sec_reg[0])
                    begin
                        sec_reg <= sec_reg + 1'b1;
                    end
                    else
                    begin
                        sec_reg <= lr4xo_pkg::sec_idx_t'(2);
                    end
                end
                lr4xo_pkg::ST_GAIN:  cnt_reg <= cnt_reg + 1'b1;
                default:             cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg    <= x_in;
            last_reg <= block_end;
        end
        if (state_reg == lr4xo_pkg::ST_LOAD)
        begin
            hist_reg <= mem_rd_data;
            xs_reg   <= xs_next;
        end
        if (state_reg == lr4xo_pkg::ST_WRITE)
        begin
            // Section output feeds the next section or the gain stage
            x_reg <= sec_y;
        end
        if (out_load)
        begin
            out_sample_reg <= out_y;
            block_last_reg <= last_reg;
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign block_last = block_last_reg;

    lr4xo_hist_mem u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (sec_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (sec_reg),
        .wr_data (mem_wr_data)
    );

    lr4xo_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .sec_y (sec_y),
        .out_y (out_y)
    );

endmodule
`default_nettype wire

// File: tb/sv/lr4_band_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr4_band_checker
// Tracks the register writes and both sample channels of the crossover
// filter, keeps its own copy of the section history and checks every output
// beat, in order, against the value it computes.
// ----------------------------------------------------------------------------
module lr4_band_checker
    import lr4xo_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample,
    input  logic                              block_end,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [SAMPLE_BITS_DEF-1:0] out_sample,
    input  logic                              block_last,
    output int                                mismatch_count,
    output int                                results_owed
);

    localparam int SW        = SAMPLE_BITS_DEF;
    localparam int COEF_FRAC = COEF_BITS_DEF - 2;
    localparam int OUT_SHIFT = 60 - SW - 1;

    localparam logic signed [79:0] SECTION_ROUND = 80'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [79:0] HIST_MAX      = 80'sd2147483647;
    localparam logic signed [79:0] HIST_MIN      = -80'sd2147483648;
    localparam logic signed [79:0] SAMPLE_MAX    = (80'sd1 <<< (SW - 1)) - 80'sd1;
    localparam logic signed [79:0] SAMPLE_MIN    = -(80'sd1 <<< (SW - 1));

    typedef struct {
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic signed [31:0] y1;
        logic signed [31:0] y2;
    } biquad_taps_t;

    typedef struct {
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } biquad_coef_t;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
    } filtered_beat_t;

    logic [MODE_W-1:0]    mode;
    biquad_coef_t         lp_coef;
    biquad_coef_t         hp_coef;
    logic [GAIN_BITS-1:0] gain;
    biquad_taps_t         lp_taps [2];
    biquad_taps_t         hp_taps [2];
    filtered_beat_t       filtered_q [$];

    // One Direct Form I section; the new output lands in y1 of the result.
    function automatic biquad_taps_t biquad_step(input biquad_taps_t t,
                                                 input biquad_coef_t c,
                                                 input bit highpass,
                                                 input logic signed [31:0] x0);
        logic signed [79:0] x0w, x1w, x2w, y1w, y2w, b0w, a1w, a2w, xs, acc;
        logic signed [31:0] y;
        biquad_taps_t       n;
        x0w = x0;
        x1w = t.x1;
        x2w = t.x2;
        y1w = t.y1;
        y2w = t.y2;
        b0w = c.b0;
        a1w = c.a1;
        a2w = c.a2;
        xs  = highpass ? (x0w - 80'sd2 * x1w + x2w) : (x0w + 80'sd2 * x1w + x2w);
        acc = b0w * xs - a1w * y1w - a2w * y2w + SECTION_ROUND;
        acc = acc >>> COEF_FRAC;
        if (acc > HIST_MAX)
            y = 32'sh7FFF_FFFF;
        else if (acc < HIST_MIN)
            y = 32'sh8000_0000;
        else
            y = acc[31:0];
        n.x2 = t.x1;
        n.x1 = x0;
        n.y2 = t.y1;
        n.y1 = y;
        return n;
    endfunction

    // Run one sample through the active cascades, then gain and saturation.
    function automatic filtered_beat_t filter_sample(input logic signed [SW-1:0] s,
                                                     input logic e);
        logic signed [31:0] x;
        logic signed [79:0] yw, gw, p;
        filtered_beat_t     r;
        x = {s, {(32 - SW){1'b0}}};
        if (mode != MODE_HP)
        begin
            lp_taps[0] = biquad_step(lp_taps[0], lp_coef, 1'b0, x);
            lp_taps[1] = biquad_step(lp_taps[1], lp_coef, 1'b0, lp_taps[0].y1);
            x = lp_taps[1].y1;
        end
        if (mode != MODE_LP)
        begin
            hp_taps[0] = biquad_step(hp_taps[0], hp_coef, 1'b1, x);
            hp_taps[1] = biquad_step(hp_taps[1], hp_coef, 1'b1, hp_taps[0].y1);
            x = hp_taps[1].y1;
        end
        yw = x;
        gw = $signed({48'd0, gain});
        p  = (yw * gw) >>> OUT_SHIFT;
        p  = (p + 80'sd1) >>> 1;
        if (p > SAMPLE_MAX)
            r.sample = {1'b0, {(SW - 1){1'b1}}};
        else if (p < SAMPLE_MIN)
            r.sample = {1'b1, {(SW - 1){1'b0}}};
        else
            r.sample = p[SW-1:0];
        r.last = e;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_beat_t want;
        if (!rst_n)
        begin
            mode    = MODE_LP;
            lp_coef = '{default: 0};
            hp_coef = '{default: 0};
            gain    = GAIN_RESET;
            for (int i = 0; i < 2; i++)
            begin
                lp_taps[i] = '{default: 0};
                hp_taps[i] = '{default: 0};
            end
            filtered_q.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FILTER_MODE: mode       = cfg_data[MODE_W-1:0];
                    REG_LP_B0:       lp_coef.b0 = cfg_data;
                    REG_LP_A1:       lp_coef.a1 = cfg_data;
                    REG_LP_A2:       lp_coef.a2 = cfg_data;
                    REG_HP_B0:       hp_coef.b0 = cfg_data;
                    REG_HP_A1:       hp_coef.a1 = cfg_data;
                    REG_HP_A2:       hp_coef.a2 = cfg_data;
                    REG_OUT_GAIN:    gain       = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                filtered_q.push_back(filter_sample(in_sample, block_end));
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected, out_sample %0d",
                             $time, out_sample);
                    mismatch_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_sample !== want.sample)
                    begin
                        $display("%0t: out_sample expected %0d, actual %0d",
                                 $time, want.sample, out_sample);
                        mismatch_count++;
                    end
                    if (block_last !== want.last)
                    begin
                        $display("%0t: block_last expected %0b, actual %0b",
                                 $time, want.last, block_last);
                        mismatch_count++;
                    end
                end
            end
            results_owed = filtered_q.size();
        end
    end

endmodule

// File: tb/sv/tb_lr4_crossover_band_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lr4_crossover_band_filter
// Drives the crossover filter through a short corner-value run in every mode
// and then through eight register settings, some random, with random stalls
// on both channels in the first six; the checker computes and compares.
// ----------------------------------------------------------------------------
module tb_lr4_crossover_band_filter;
    import lr4xo_pkg::*;

    localparam int SW             = SAMPLE_BITS_DEF;
    localparam int NUM_REGS       = 1 << CFG_IDX_W;
    localparam int WATCHDOG_LIMIT = 2000;
    // give the block margin after the last beat, enough for a band-pass sample
    localparam int TAIL_CYCLES    = 60;

    // Band-pass runs on any code other than the two single cascades.
    localparam logic [MODE_W-1:0] MODE_BP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

    // Q2.30 Butterworth sections at 48 kHz: low-pass near 1 kHz, high-pass near 5 kHz.
    localparam logic [31:0] LP_B0 = 32'sd4206920;
    localparam logic [31:0] LP_A1 = -32'sd1949174270;
    localparam logic [31:0] LP_A2 = 32'sd892257981;
    localparam logic [31:0] HP_B0 = 32'sd673085799;
    localparam logic [31:0] HP_A1 = -32'sd1191037381;
    localparam logic [31:0] HP_A2 = 32'sd427531782;

    localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COEF_MIN = 32'h8000_0000;
    localparam logic [31:0] GAIN_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] GAIN_X2  = 32'h2000_0000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic signed [SW-1:0] in_sample = '0;
    logic                 block_end = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [SW-1:0] out_sample;
    logic                 block_last;

    int mismatch_count;
    int results_owed;
    int send_idle_pct = 36;
    int recv_idle_pct = 51;
    int stall_cycles  = 0;

    always #5 clk = ~clk;

    lr4_crossover_band_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_sample  (in_sample),
        .block_end  (block_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .block_last (block_last)
    );

    lr4_band_checker band_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_sample      (in_sample),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_sample     (out_sample),
        .block_last     (block_last),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Receiver: drop ready at random, one decision per cycle at the falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one input beat and hold it until accepted. Enter and leave at a
    // falling edge; valid stays high on exit so back-to-back beats need no gap.
    task automatic send_beat(input logic signed [SW-1:0] s, input logic e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        block_end <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender off until every outstanding output beat has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Reprogram all eight registers once the block has gone idle.
    task automatic apply_filter(input logic [MODE_W-1:0] mode,
                                input logic [31:0] lp_b0, lp_a1, lp_a2,
                                input logic [31:0] hp_b0, hp_a1, hp_a2,
                                input logic [31:0] gain);
        logic [31:0] regs [NUM_REGS];
        regs[REG_FILTER_MODE] = 32'(mode);
        regs[REG_LP_B0]       = lp_b0;
        regs[REG_LP_A1]       = lp_a1;
        regs[REG_LP_A2]       = lp_a2;
        regs[REG_HP_B0]       = hp_b0;
        regs[REG_HP_A1]       = hp_a1;
        regs[REG_HP_A2]       = hp_a2;
        regs[REG_OUT_GAIN]    = gain;
        drain_results();
        repeat (4) @(negedge clk);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= regs[i];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly full-scale noise, with small values and rails mixed in.
    function automatic logic signed [SW-1:0] pick_sample();
        int unsigned pick;
        logic signed [SW-1:0] v;
        pick = $urandom_range(99);
        if (pick < 10)
            v = $urandom_range(1) ? {1'b0, {(SW - 1){1'b1}}} : {1'b1, {(SW - 1){1'b0}}};
        else if (pick < 30)
            v = SW'($urandom_range(2000)) - SW'(1000);
        else
            v = SW'($urandom);
        return v;
    endfunction

    initial
    begin
        logic signed [SW-1:0] corner_vals [5];
        int beats;
        corner_vals = '{{1'b0, {(SW - 1){1'b1}}}, {1'b1, {(SW - 1){1'b0}}},
                        '0, SW'(1), '1};

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values: zero coefficients, unity gain, low-pass.
        send_beat(corner_vals[0], 1'b0);
        send_beat(corner_vals[1], 1'b1);

        // Corner samples through each mode; history of the idle cascade is
        // carried over untouched between the mode switches.
        apply_filter(MODE_LP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, GAIN_RESET);
        for (int i = 0; i < 5; i++)
            send_beat(corner_vals[i], i[0]);
        apply_filter(MODE_HP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, GAIN_RESET);
        for (int i = 0; i < 4; i++)
            send_beat(corner_vals[i], i[0]);
        apply_filter(MODE_BP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, GAIN_RESET);
        for (int i = 0; i < 4; i++)
            send_beat(corner_vals[i], i[0]);
        apply_filter(MODE_UNDEF, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, GAIN_RESET);
        for (int i = 0; i < 3; i++)
            send_beat(corner_vals[i], i[0]);

        // Rail coefficients and full gain: sections and output must saturate.
        apply_filter(MODE_BP, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
                     GAIN_MAX);
        for (int i = 0; i < 4; i++)
            send_beat(corner_vals[i], i[0]);

        // Random part: eight register settings, roughly a hundred beats each.
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 36;
            end
            if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: apply_filter(MODE_LP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2,
                                GAIN_RESET);
                1: apply_filter(MODE_HP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2,
                                GAIN_X2);
                2: apply_filter(MODE_BP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2,
                                $urandom);
                3: apply_filter(MODE_UNDEF, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2,
                                GAIN_MAX);
                4: apply_filter(MODE_W'($urandom_range(3)), $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
                5: apply_filter(MODE_BP, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
                                COEF_MIN, '0);
                6: apply_filter(MODE_HP, LP_B0, LP_A1, LP_A2, $urandom, $urandom, $urandom,
                                GAIN_RESET);
                default: apply_filter(MODE_BP, LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2,
                                      GAIN_RESET);
            endcase
            beats = 90 + $urandom_range(20);
            for (int k = 0; k < beats; k++)
            begin
                // now and then let the pipeline run dry before the next beat
                if ($urandom_range(49) == 0)
                    drain_results();
                send_beat(pick_sample(), ($urandom_range(7) == 0));
            end
        end

        // Stop sending, wait out the owed beats and then the tail margin.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/lr4xo_pkg.sv
hdl/lr4xo_hist_mem.sv
hdl/lr4xo_mac.sv
hdl/lr4_crossover_band_filter.sv
tb/sv/lr4_band_checker.sv
tb/sv/tb_lr4_crossover_band_filter.sv
